[hw/rtl/rvmf_pkg.sv]
package rvmf_pkg;

  localparam int SET_DEPTH = 64;
  localparam int ADDR_W    = $clog2(SET_DEPTH);
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);

  localparam int SAMPLE_W  = 24;
  localparam int VALUE_W   = 16;
  localparam int MCOUNT_W  = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CAND,
    ST_SWEEP,
    ST_TALLY,
    ST_OUT
  } rvmf_state_t;

endpackage

[hw/rtl/rounded_value_mode_finder.sv]
// Collects a set of signed Q16.8 samples, rounds each half away from zero to a
// saturated 16-bit integer and keeps it in a 64-entry store. Items without the
// last-of-set mark are taken one per cycle. The item that closes a set starts a
// scan over the n stored values: for each candidate the block reads the store
// once, then sweeps all n entries through its single read port and one
// compare/count unit, and no item is taken until the result has been delivered.
// The mode is the most frequent value, the smallest one on a tie; elements that
// arrive while the store is full are dropped and reported by the overflow flag.
module rounded_value_mode_finder
  import rvmf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic                       in_last_of_set,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [VALUE_W-1:0]  out_mode_value,
  output logic [MCOUNT_W-1:0]        out_mode_count,
  output logic                       out_overflow_seen
);

  rvmf_state_t state_r, state_nxt;

  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [ADDR_W-1:0]         i_r, i_nxt;
  logic [ADDR_W-1:0]         j_r, j_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      cmp_pend_r, cmp_pend_nxt;
  logic signed [VALUE_W-1:0] cand_r, cand_nxt;
  logic signed [VALUE_W-1:0] best_val_r, best_val_nxt;
  logic [CNT_W-1:0]          best_cnt_r, best_cnt_nxt;

  logic signed [VALUE_W-1:0] store_mem [SET_DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]         rd_addr;
  logic                      wr_en;

  logic                      in_acc;
  logic                      full;
  logic                      smp_neg;
  logic [SAMPLE_W-1:0]       smp_mag;
  logic [SAMPLE_W:0]         smp_sum;
  logic [SAMPLE_W-8:0]       smp_q;
  logic signed [VALUE_W-1:0] smp_rnd;
  logic                      hit;
  logic [CNT_W-1:0]          cnt_final;
  logic                      last_j;
  logic                      last_i;

  // Round half away from zero on the magnitude, then restore the sign.
  always_comb begin
    smp_neg = in_sample_value[SAMPLE_W-1];
    smp_mag = smp_neg ? (~in_sample_value + SAMPLE_W'(1)) : in_sample_value;
    smp_sum = {1'b0, smp_mag} + (SAMPLE_W+1)'(128);
    smp_q   = smp_sum[SAMPLE_W:8];
    if (smp_neg) begin
      smp_rnd = VALUE_W'(~smp_q + (SAMPLE_W-7)'(1));
    end else if (smp_q > (SAMPLE_W-7)'(32767)) begin
      smp_rnd = 16'sh7fff;
    end else begin
      smp_rnd = VALUE_W'(smp_q);
    end
  end

  assign in_acc    = in_valid && !in_stall;
  assign full      = (fill_r == CNT_W'(SET_DEPTH));
  assign wr_en     = in_acc && !full;
  assign hit       = cmp_pend_r && (rd_data_r == cand_r);
  assign cnt_final = cnt_r + CNT_W'(hit);
  assign last_j    = (j_r == ADDR_W'(fill_r - CNT_W'(1)));
  assign last_i    = (i_r == ADDR_W'(fill_r - CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[fill_r[ADDR_W-1:0]] <= smp_rnd;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    ovf_nxt      = ovf_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    cnt_nxt      = cnt_r;
    cmp_pend_nxt = cmp_pend_r;
    cand_nxt     = cand_r;
    best_val_nxt = best_val_r;
    best_cnt_nxt = best_cnt_r;
    rd_addr      = i_r;
    in_stall     = 1'b1;
    out_valid    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            fill_nxt = fill_r + CNT_W'(1);
          end
          if (in_last_of_set) begin
            i_nxt        = '0;
            best_cnt_nxt = '0;
            best_val_nxt = '0;
            state_nxt    = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        rd_addr   = i_r;
        state_nxt = ST_CAND;
      end
      ST_CAND: begin
        cand_nxt     = rd_data_r;
        cnt_nxt      = '0;
        j_nxt        = '0;
        cmp_pend_nxt = 1'b0;
        state_nxt    = ST_SWEEP;
      end
      ST_SWEEP: begin
        // Read entry j while comparing the entry fetched in the cycle before.
        rd_addr      = j_r;
        cnt_nxt      = cnt_final;
        cmp_pend_nxt = 1'b1;
        j_nxt        = j_r + ADDR_W'(1);
        if (last_j) begin
          state_nxt = ST_TALLY;
        end
      end
      ST_TALLY: begin
        if ((cnt_final > best_cnt_r) ||
            ((cnt_final == best_cnt_r) && (cand_r < best_val_r))) begin
          best_cnt_nxt = cnt_final;
          best_val_nxt = cand_r;
        end
        i_nxt = i_r + ADDR_W'(1);
        if (last_i) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          fill_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      ovf_r      <= 1'b0;
      cmp_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      ovf_r      <= ovf_nxt;
      cmp_pend_r <= cmp_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    cnt_r      <= cnt_nxt;
    cand_r     <= cand_nxt;
    best_val_r <= best_val_nxt;
    best_cnt_r <= best_cnt_nxt;
  end

  assign out_mode_value    = best_val_r;
  assign out_mode_count    = MCOUNT_W'(best_cnt_r);
  assign out_overflow_seen = ovf_r;

endmodule

[hw/rtl/rvmf_checker.sv]
module rvmf_checker
  import rvmf_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic signed [SAMPLE_W-1:0] in_sample_value,
  input logic                       in_last_of_set,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [VALUE_W-1:0]  out_mode_value,
  input logic [MCOUNT_W-1:0]        out_mode_count,
  input logic                       out_overflow_seen
);

  // No item is taken while a result is on offer.
  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  // The item that closes a set starts the scan.
  a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_of_set) |=> in_stall)
    else $error("input not stalled after the last item of a set");

  // Exactly one result per set.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("result offered twice");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_mode_value) && $stable(out_mode_count) &&
       $stable(out_overflow_seen)))
    else $error("stalled result changed");

endmodule

bind rounded_value_mode_finder rvmf_checker u_rvmf_checker (.*);
